/* hdl/gn2_pkg.sv */
`timescale 1ns / 1ps
package gn2_pkg;

    localparam int FRAC = 24;
    localparam longint NANO = 64'sd1000000000;

    // widths of the internal datapath
    localparam int XW = 42;
    localparam int BW = XW - FRAC;
    localparam int DW = 28;
    localparam int GW = 30;
    localparam int CW = 36;
    localparam int SW = 38;

    localparam logic [63:0] MUL_PX   = 64'h5205402B9270C86F;
    localparam logic [63:0] MUL_PY   = 64'h598CD327003817B5;
    localparam logic [63:0] HASH_MIX = 64'h53A3F72DEEC546F5;

    localparam logic [0:0] REG_SEED   = 1'b0;
    localparam logic [0:0] REG_ORIENT = 1'b1;

    typedef logic signed [DW-1:0] t_fix;
    typedef logic signed [GW-1:0] t_grad;

    typedef struct packed {
        t_grad gx;
        t_grad gy;
    } t_grad_pair;

    // decimal constant in units of 1e-9 to fixed point, rounding half up on magnitude
    function automatic longint nano_fix(input longint v);
        longint unsigned m;
        longint unsigned ip;
        longint unsigned fr;
        longint unsigned r;
        m  = (v < 0) ? 64'(-v) : 64'(v);
        ip = m / NANO;
        fr = m % NANO;
        r  = (ip << FRAC) + ((fr << FRAC) + NANO / 2) / NANO;
        nano_fix = (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    // product rounding: magnitude to nearest, ties away from zero
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] p, input int sh);
        logic [63:0] m;
        logic [63:0] r;
        m = p[63] ? 64'(-p) : 64'(p);
        r = (m + (64'd1 << (sh - 1))) >> sh;
        rnd_shift = p[63] ? -$signed(r) : $signed(r);
    endfunction

    localparam longint Q_SKEW   = nano_fix(64'sd366025404);
    localparam longint Q_UNSKEW = nano_fix(-64'sd211324865);
    localparam longint Q_RSQ    = nano_fix(64'sd666666667);
    localparam longint Q_R2O2   = nano_fix(64'sd707106781);
    localparam longint Q_YROT   = nano_fix(64'sd1224744871);
    localparam longint Q_A1LIN  = nano_fix(-64'sd3154700538);
    localparam longint Q_A1C    = nano_fix(-64'sd666666667);
    localparam longint Q_U3P2   = nano_fix(64'sd1366025404);
    localparam longint Q_U3P1   = nano_fix(64'sd366025404);
    localparam longint Q_UP1    = nano_fix(64'sd788675135);
    localparam longint Q_U2P1   = nano_fix(64'sd577350269);

    localparam longint GRAD_MAG [6] = '{
        nano_fix(64'sd6980896500), nano_fix(64'sd16853374000), nano_fix(64'sd2381053700),
        nano_fix(64'sd18085900000), nano_fix(64'sd11105002000), nano_fix(64'sd14472321500)
    };

    localparam logic signed [25:0] KQ_SKEW  = 26'(Q_SKEW);
    localparam logic signed [25:0] KQ_R2O2  = 26'(Q_R2O2);
    localparam logic signed [25:0] KQ_YROT  = 26'(Q_YROT);
    localparam logic signed [25:0] KQ_U     = 26'(Q_UNSKEW);
    localparam logic [21:0]        KQ_UMAG  = 22'(-Q_UNSKEW);
    localparam logic signed [27:0] KQ_A1LIN = 28'(Q_A1LIN);

    localparam t_fix K_RSQ  = t_fix'(Q_RSQ);
    localparam t_fix K_A1C  = t_fix'(Q_A1C);
    localparam t_fix K_U    = t_fix'(Q_UNSKEW);
    localparam t_fix K_UP1  = t_fix'(Q_UP1);
    localparam t_fix K_U2P1 = t_fix'(Q_U2P1);
    localparam t_fix K_U3P1 = t_fix'(Q_U3P1);
    localparam t_fix K_U3P2 = t_fix'(Q_U3P2);

    localparam logic signed [3:0] PAIR_X [24] = '{
        4'sd1, 4'sd2, 4'sd2, 4'sd1, -4'sd1, -4'sd2, -4'sd2, -4'sd1,
        4'sd3, 4'sd5, 4'sd6, 4'sd4, 4'sd4, 4'sd6, 4'sd5, 4'sd3,
        -4'sd3, -4'sd5, -4'sd6, -4'sd4, -4'sd4, -4'sd6, -4'sd5, -4'sd3
    };
    localparam logic signed [3:0] PAIR_Y [24] = '{
        4'sd2, 4'sd1, -4'sd1, -4'sd2, -4'sd2, -4'sd1, 4'sd1, 4'sd2,
        4'sd4, 4'sd6, 4'sd5, 4'sd3, -4'sd3, -4'sd5, -4'sd6, -4'sd4,
        -4'sd4, -4'sd6, -4'sd5, -4'sd3, 4'sd3, 4'sd5, 4'sd6, 4'sd4
    };

    function automatic t_grad grad_comp(input logic signed [3:0] c);
        logic [3:0] m;
        t_grad g;
        m = c[3] ? 4'(-c) : 4'(c);
        g = t_grad'(GRAD_MAG[3'(m - 4'd1)]);
        grad_comp = c[3] ? -g : g;
    endfunction

    // 7-bit hash slice reduced mod 24, then the signed gradient pair
    function automatic t_grad_pair grad_lookup(input logic [6:0] idx);
        logic [6:0] p;
        t_grad_pair g;
        p = idx;
        if (p >= 7'd96) p = p - 7'd96;
        if (p >= 7'd48) p = p - 7'd48;
        if (p >= 7'd24) p = p - 7'd24;
        g.gx = grad_comp(PAIR_X[5'(p)]);
        g.gy = grad_comp(PAIR_Y[5'(p)]);
        grad_lookup = g;
    endfunction

endpackage

/* hdl/gradient_noise_2d_core.sv */
`timescale 1ns / 1ps
// 2D smooth gradient noise (OpenSimplex2S style) on a Q16.16 coordinate.
// Input: pulse start with i_x_coord / i_y_coord; busy is always low, so a
// coordinate is taken on every cycle that start is high.
// Output: o_noise_value (Q2.14, saturated) is valid for one cycle while
// o_strobe is high; there is no back-pressure, the receiver must take it.
// Throughput: one sample per clock, set by the fixed 15-stage pipeline
// in which every multiplier is followed by a register.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 seed, 1 orientation bit). Write only while no sample is in flight.
// Reset (i_rst_n low, synchronous) clears the seed, the orientation and
// all pipeline valid bits; samples in flight are dropped.
module gradient_noise_2d_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_x_coord,
    input  logic signed [31:0] i_y_coord,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data,
    output logic               o_strobe,
    output logic signed [15:0] o_noise_value
);
    import gn2_pkg::*;

    localparam int DEPTH = 15;
    localparam int SQV [3] = '{0, 2, 3};

    logic [63:0]      r_noise_seed;
    logic             r_orientation;
    logic [DEPTH-1:0] r_vld;

    // stage registers
    logic signed [31:0] r0_x, r0_y;
    logic signed [58:0] r1_pa;
    logic signed [57:0] r1_pb;
    logic signed [31:0] r1_x, r1_y;
    logic               r1_ori;
    logic signed [XW-1:0] r2_xs, r2_ys;
    logic signed [50:0] r3_px0, r3_py0;
    logic [31:0]        r3_px1, r3_py1;
    logic [46:0]        r3_tp;
    logic [FRAC-1:0]    r3_xi, r3_yi;
    logic [63:0]        r4_xp, r4_yp;
    t_fix               r4_dx, r4_dy;
    logic signed [25:0] r4_t;
    logic               r4_lo, r4_c2, r4_c3;
    logic [63:0]        r5_key [4];
    t_fix               r5_dx [4], r5_dy [4];
    logic signed [53:0] r5_pa1;
    logic [63:0]        r6_m00 [4];
    logic [31:0]        r6_m01 [4], r6_m10 [4];
    logic signed [55:0] r6_sx [3], r6_sy [3];
    t_fix               r6_dx [4], r6_dy [4];
    logic signed [53:0] r6_pa1;
    logic [6:0]         r7_idx [4];
    t_fix               r7_a [4], r7_dx [4], r7_dy [4];
    logic signed [57:0] r8_pgx [4], r8_pgy [4];
    logic signed [55:0] r8_paa [4];
    logic signed [31:0] r9_dot [4];
    t_fix               r9_a2 [4];
    logic signed [55:0] r10_pa4 [4];
    logic signed [31:0] r10_dot [4];
    t_fix               r11_a4 [4];
    logic signed [31:0] r11_dot [4];
    logic signed [59:0] r12_pc [4];
    logic signed [SW-1:0] r13_sum;
    logic signed [15:0] r_out;

    // combinational helpers
    logic signed [32:0]   s1_opa;
    logic signed [25:0]   s1_ka;
    logic signed [XW-1:0] s2_sa, s2_sb, s2_xq, s2_yq, n_xs, n_ys;
    logic signed [BW-1:0] s3_xb, s3_yb;
    logic [22:0]          s4_tmag;
    logic signed [25:0]   s4_t, s4_xmyi;
    logic signed [26:0]   s4_sum2, s4_d3;
    logic                 s4_lo;
    logic [63:0]          s5_xo [4], s5_yo [4];
    t_fix                 s5_ddx [4], s5_ddy [4];
    logic [63:0]          s7_h [4];
    t_fix                 s7_a [4];
    t_grad_pair           s8_g [4];
    logic signed [CW-1:0] s13_c [4];
    logic [SW-1:0]        s14_mag, s14_rq;
    logic signed [15:0]   n_out;

    assign busy          = 1'b0;
    assign o_strobe      = r_vld[DEPTH-1];
    assign o_noise_value = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise_seed  <= '0;
            r_orientation <= 1'b0;
            r_vld         <= '0;
        end else begin
            r_vld <= {r_vld[DEPTH-2:0], start};
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SEED:   r_noise_seed  <= i_cfg_data;
                    REG_ORIENT: r_orientation <= i_cfg_data[0];
                    default:    ;
                endcase
            end
        end
    end

    // skew: one product pair, rounded in the next stage
    assign s1_opa = r_orientation ? 33'(r0_x) : (33'(r0_x) + 33'(r0_y));
    assign s1_ka  = r_orientation ? KQ_R2O2 : KQ_SKEW;

    always_comb begin
        s2_sa = XW'(rnd_shift(64'(r1_pa), 16));
        s2_sb = XW'(rnd_shift(64'(r1_pb), 16));
        s2_xq = XW'(r1_x) <<< (FRAC - 16);
        s2_yq = XW'(r1_y) <<< (FRAC - 16);
        if (r1_ori) begin
            n_xs = s2_sb + s2_sa;
            n_ys = s2_sb - s2_sa;
        end else begin
            n_xs = s2_xq + s2_sa;
            n_ys = s2_yq + s2_sa;
        end
    end

    assign s3_xb = r2_xs[XW-1:FRAC];
    assign s3_yb = r2_ys[XW-1:FRAC];

    // cell offsets and the region tests
    always_comb begin
        s4_tmag = 23'((r3_tp + (47'd1 << (FRAC - 1))) >> FRAC);
        s4_t    = -$signed({3'b0, s4_tmag});
        s4_xmyi = $signed({2'b0, r3_xi}) - $signed({2'b0, r3_yi});
        s4_sum2 = $signed({3'b0, r3_xi}) + 27'(s4_xmyi);
        s4_d3   = $signed({3'b0, r3_yi}) - 27'(s4_xmyi);
        s4_lo   = s4_t < KQ_U;
    end

    // per-vertex lattice step and offset
    always_comb begin
        s5_xo[0] = '0;      s5_yo[0] = '0;      s5_ddx[0] = '0;      s5_ddy[0] = '0;
        s5_xo[1] = MUL_PX;  s5_yo[1] = MUL_PY;  s5_ddx[1] = -K_U2P1; s5_ddy[1] = -K_U2P1;
        if (r4_lo) begin
            if (r4_c2) begin
                s5_xo[2] = MUL_PX << 1; s5_yo[2] = MUL_PY; s5_ddx[2] = -K_U3P2; s5_ddy[2] = -K_U3P1;
            end else begin
                s5_xo[2] = '0; s5_yo[2] = MUL_PY; s5_ddx[2] = -K_U; s5_ddy[2] = -K_UP1;
            end
            if (r4_c3) begin
                s5_xo[3] = MUL_PX; s5_yo[3] = MUL_PY << 1; s5_ddx[3] = -K_U3P1; s5_ddy[3] = -K_U3P2;
            end else begin
                s5_xo[3] = MUL_PX; s5_yo[3] = '0; s5_ddx[3] = -K_UP1; s5_ddy[3] = -K_U;
            end
        end else begin
            if (r4_c2) begin
                s5_xo[2] = 64'(0) - MUL_PX; s5_yo[2] = '0; s5_ddx[2] = K_UP1; s5_ddy[2] = K_U;
            end else begin
                s5_xo[2] = MUL_PX; s5_yo[2] = '0; s5_ddx[2] = -K_UP1; s5_ddy[2] = -K_U;
            end
            if (r4_c3) begin
                s5_xo[3] = '0; s5_yo[3] = 64'(0) - MUL_PY; s5_ddx[3] = K_U; s5_ddy[3] = K_UP1;
            end else begin
                s5_xo[3] = '0; s5_yo[3] = MUL_PY; s5_ddx[3] = -K_U; s5_ddy[3] = -K_UP1;
            end
        end
    end

    // hash finish and falloff
    always_comb begin
        for (int v = 0; v < 4; v++) begin
            s7_h[v] = r6_m00[v] + {r6_m01[v] + r6_m10[v], 32'd0};
            s7_a[v] = '0;
        end
        for (int j = 0; j < 3; j++) begin
            s7_a[SQV[j]] = K_RSQ - t_fix'(rnd_shift(64'(r6_sx[j]), FRAC))
                                 - t_fix'(rnd_shift(64'(r6_sy[j]), FRAC));
        end
        s7_a[1] = t_fix'(rnd_shift(64'(r6_pa1), FRAC)) + K_A1C + s7_a[0];
        // outer vertices only count with positive falloff; zero falloff gives zero
        for (int v = 2; v < 4; v++) begin
            if (s7_a[v] <= 0) s7_a[v] = '0;
        end
    end

    always_comb begin
        for (int v = 0; v < 4; v++) begin
            s8_g[v]  = grad_lookup(r7_idx[v]);
            s13_c[v] = CW'(rnd_shift(64'(r12_pc[v]), FRAC));
        end
    end

    // final rounding to Q2.14 with saturation
    always_comb begin
        s14_mag = r13_sum[SW-1] ? SW'(-r13_sum) : SW'(r13_sum);
        s14_rq  = (s14_mag + (SW'(1) << (FRAC - 15))) >> (FRAC - 14);
        if (r13_sum[SW-1]) begin
            n_out = (s14_rq > SW'(32768)) ? -16'sd32768 : 16'(-s14_rq);
        end else begin
            n_out = (s14_rq > SW'(32767)) ? 16'sd32767 : 16'(s14_rq);
        end
    end

    always_ff @(posedge i_clk) begin
        r0_x <= i_x_coord;
        r0_y <= i_y_coord;

        r1_pa  <= s1_opa * s1_ka;
        r1_pb  <= r0_y * KQ_YROT;
        r1_x   <= r0_x;
        r1_y   <= r0_y;
        r1_ori <= r_orientation;

        r2_xs <= n_xs;
        r2_ys <= n_ys;

        r3_px0 <= s3_xb * $signed({1'b0, MUL_PX[31:0]});
        r3_px1 <= 32'(s3_xb * $signed({1'b0, MUL_PX[63:32]}));
        r3_py0 <= s3_yb * $signed({1'b0, MUL_PY[31:0]});
        r3_py1 <= 32'(s3_yb * $signed({1'b0, MUL_PY[63:32]}));
        r3_tp  <= (25'(r2_xs[FRAC-1:0]) + 25'(r2_ys[FRAC-1:0])) * KQ_UMAG;
        r3_xi  <= r2_xs[FRAC-1:0];
        r3_yi  <= r2_ys[FRAC-1:0];

        r4_xp <= 64'(r3_px0) + {r3_px1, 32'd0};
        r4_yp <= 64'(r3_py0) + {r3_py1, 32'd0};
        r4_dx <= $signed({4'b0, r3_xi}) + t_fix'(s4_t);
        r4_dy <= $signed({4'b0, r3_yi}) + t_fix'(s4_t);
        r4_t  <= s4_t;
        r4_lo <= s4_lo;
        r4_c2 <= s4_lo ? (s4_sum2 > 27'sd16777216) : (s4_sum2 < 0);
        r4_c3 <= s4_lo ? (s4_d3 > 27'sd16777216) : (r3_yi < 24'(s4_xmyi) && !s4_xmyi[25]);

        r5_pa1 <= KQ_A1LIN * r4_t;
        r6_pa1 <= r5_pa1;
        for (int v = 0; v < 4; v++) begin
            r5_key[v] <= r_noise_seed ^ (r4_xp + s5_xo[v]) ^ (r4_yp + s5_yo[v]);
            r5_dx[v]  <= r4_dx + s5_ddx[v];
            r5_dy[v]  <= r4_dy + s5_ddy[v];

            r6_m00[v] <= r5_key[v][31:0] * HASH_MIX[31:0];
            r6_m01[v] <= 32'(r5_key[v][31:0] * HASH_MIX[63:32]);
            r6_m10[v] <= 32'(r5_key[v][63:32] * HASH_MIX[31:0]);
            r6_dx[v]  <= r5_dx[v];
            r6_dy[v]  <= r5_dy[v];

            r7_idx[v] <= {s7_h[v][7] ^ s7_h[v][63], s7_h[v][6] ^ s7_h[v][63],
                          s7_h[v][5:1] ^ s7_h[v][63:59]};
            r7_a[v]   <= s7_a[v];
            r7_dx[v]  <= r6_dx[v];
            r7_dy[v]  <= r6_dy[v];

            r8_pgx[v] <= s8_g[v].gx * r7_dx[v];
            r8_pgy[v] <= s8_g[v].gy * r7_dy[v];
            r8_paa[v] <= r7_a[v] * r7_a[v];

            r9_dot[v] <= 32'(rnd_shift(64'(r8_pgx[v]), FRAC))
                       + 32'(rnd_shift(64'(r8_pgy[v]), FRAC));
            r9_a2[v]  <= t_fix'(rnd_shift(64'(r8_paa[v]), FRAC));

            r10_pa4[v] <= r9_a2[v] * r9_a2[v];
            r10_dot[v] <= r9_dot[v];

            r11_a4[v]  <= t_fix'(rnd_shift(64'(r10_pa4[v]), FRAC));
            r11_dot[v] <= r10_dot[v];

            r12_pc[v] <= r11_a4[v] * r11_dot[v];
        end
        for (int j = 0; j < 3; j++) begin
            r6_sx[j] <= r5_dx[SQV[j]] * r5_dx[SQV[j]];
            r6_sy[j] <= r5_dy[SQV[j]] * r5_dy[SQV[j]];
        end

        r13_sum <= SW'(s13_c[0]) + SW'(s13_c[1]) + SW'(s13_c[2]) + SW'(s13_c[3]);
        r_out   <= n_out;
    end

endmodule

/* tb/gradient_noise_2d_core_tb.sv */
`timescale 1ns / 1ps
module gradient_noise_2d_core_tb;
    import gn2_pkg::*;

    localparam int  FB        = 24;
    localparam longint ONE    = longint'(1) << FB;
    localparam int  LATENCY   = 14;
    localparam longint LIMIT  = 400000;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] i_x_coord;
    logic signed [31:0] i_y_coord;
    logic               i_cfg_we;
    logic [0:0]         i_cfg_index;
    logic [63:0]        i_cfg_data;
    logic               o_strobe;
    logic signed [15:0] o_noise_value;

    gradient_noise_2d_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_x_coord(i_x_coord), .i_y_coord(i_y_coord),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_strobe(o_strobe), .o_noise_value(o_noise_value)
    );

    // signed fixed-point product: exact, magnitude rounded half away, int64 saturation
    function automatic longint qmul(input longint a, input longint b);
        logic signed [127:0] p;
        logic [127:0] m;
        logic [127:0] r;
        bit neg;
        p = 128'(a) * 128'(b);
        neg = p[127];
        m = neg ? 128'(-p) : 128'(p);
        r = (m + (128'd1 << (FB - 1))) >> FB;
        if (neg) begin
            if (r > 128'h8000000000000000) r = 128'h8000000000000000;
            return -longint'(r[63:0]);
        end
        if (r > 128'h7FFFFFFFFFFFFFFF) r = 128'h7FFFFFFFFFFFFFFF;
        return longint'(r[63:0]);
    endfunction

    function automatic longint dec_fix(input longint v);
        longint unsigned m, ip, fr, r;
        m  = (v < 0) ? -v : v;
        ip = m / 1000000000;
        fr = m % 1000000000;
        r  = (ip << FB) + ((fr << FB) + 500000000) / 1000000000;
        return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint floor_cell(input longint v);
        if (v >= 0) return v >>> FB;
        return -((-v + ONE - 1) >>> FB);
    endfunction

    class noise_scoreboard;
        logic [63:0] seed;
        bit          rotated;
        logic signed [15:0] pending[$];
        int errors;
        longint gmag[6];
        int gsx[24] = '{1,2,2,1,-1,-2,-2,-1,3,5,6,4,4,6,5,3,-3,-5,-6,-4,-4,-6,-5,-3};
        int gsy[24] = '{2,1,-1,-2,-2,-1,1,2,4,6,5,3,-3,-5,-6,-4,-4,-6,-5,-3,3,5,6,4};
        longint k_skew, k_u, k_rsq, k_r2o2, k_yrot, k_a1lin, k_a1c, k_u3p2, k_u3p1;
        longint k_up1, k_u2p1;

        function new();
            seed = 0; rotated = 0; errors = 0;
            k_skew = dec_fix(366025404);    k_u    = dec_fix(-211324865);
            k_rsq  = dec_fix(666666667);    k_r2o2 = dec_fix(707106781);
            k_yrot = dec_fix(1224744871);   k_a1lin = dec_fix(-64'sd3154700538);
            k_a1c  = dec_fix(-666666667);   k_u3p2 = dec_fix(1366025404);
            k_u3p1 = dec_fix(366025404);    k_up1  = dec_fix(788675135);
            k_u2p1 = dec_fix(577350269);
            gmag[0] = dec_fix(64'sd6980896500);  gmag[1] = dec_fix(64'sd16853374000);
            gmag[2] = dec_fix(64'sd2381053700);  gmag[3] = dec_fix(64'sd18085900000);
            gmag[4] = dec_fix(64'sd11105002000); gmag[5] = dec_fix(64'sd14472321500);
        endfunction

        function longint gsel(input int c);
            longint g;
            g = gmag[((c < 0 ? -c : c) - 1) % 6];
            return c < 0 ? -g : g;
        endfunction

        function longint vertex(input logic [63:0] xp, input logic [63:0] yp,
                                input longint dx, input longint dy, input longint a);
            logic [63:0] h;
            int p;
            longint dot, a2;
            h = (seed ^ xp ^ yp) * HASH_MIX;
            h = h ^ 64'($signed(h) >>> 58);
            p = int'(h[7:1]) % 24;
            dot = qmul(gsel(gsx[p]), dx) + qmul(gsel(gsy[p]), dy);
            a2 = qmul(a, a);
            return qmul(qmul(a2, a2), dot);
        endfunction

        function longint gated(input logic [63:0] xp, input logic [63:0] yp,
                               input longint dx, input longint dy);
            longint a;
            a = k_rsq - qmul(dx, dx) - qmul(dy, dy);
            return a > 0 ? vertex(xp, yp, dx, dy, a) : 0;
        endfunction

        function void note_input(input logic signed [31:0] xc, input logic signed [31:0] yc);
            longint xq, yq, xs, ys, xb, yb, xi, yi, t, dx0, dy0, a0, a1, xmyi, sum, s;
            logic [63:0] xp, yp;
            longint unsigned mag;
            xq = longint'(xc) * (longint'(1) << (FB - 16));
            yq = longint'(yc) * (longint'(1) << (FB - 16));
            if (rotated) begin
                xs = qmul(yq, k_yrot) + qmul(xq, k_r2o2);
                ys = qmul(yq, k_yrot) - qmul(xq, k_r2o2);
            end else begin
                s = qmul(k_skew, xq + yq);
                xs = xq + s;
                ys = yq + s;
            end
            xb = floor_cell(xs);
            yb = floor_cell(ys);
            xi = xs - xb * ONE;
            yi = ys - yb * ONE;
            xp = 64'(xb) * MUL_PX;
            yp = 64'(yb) * MUL_PY;
            t = qmul(xi + yi, k_u);
            dx0 = xi + t;
            dy0 = yi + t;
            a0 = k_rsq - qmul(dx0, dx0) - qmul(dy0, dy0);
            sum = vertex(xp, yp, dx0, dy0, a0);
            a1 = qmul(k_a1lin, t) + (k_a1c + a0);
            sum += vertex(xp + MUL_PX, yp + MUL_PY, dx0 - k_u2p1, dy0 - k_u2p1, a1);
            xmyi = xi - yi;
            if (t < k_u) begin
                if (xi + xmyi > ONE)
                    sum += gated(xp + (MUL_PX << 1), yp + MUL_PY, dx0 - k_u3p2, dy0 - k_u3p1);
                else
                    sum += gated(xp, yp + MUL_PY, dx0 - k_u, dy0 - k_up1);
                if (yi - xmyi > ONE)
                    sum += gated(xp + MUL_PX, yp + (MUL_PY << 1), dx0 - k_u3p1, dy0 - k_u3p2);
                else
                    sum += gated(xp + MUL_PX, yp, dx0 - k_up1, dy0 - k_u);
            end else begin
                if (xi + xmyi < 0)
                    sum += gated(xp - MUL_PX, yp, dx0 + k_up1, dy0 + k_u);
                else
                    sum += gated(xp + MUL_PX, yp, dx0 - k_up1, dy0 - k_u);
                if (yi < xmyi)
                    sum += gated(xp, yp - MUL_PY, dx0 + k_u, dy0 + k_up1);
                else
                    sum += gated(xp, yp + MUL_PY, dx0 - k_u, dy0 - k_up1);
            end
            mag = sum < 0 ? -sum : sum;
            mag = (mag + (longint'(1) << (FB - 15))) >> (FB - 14);
            if (sum < 0) begin
                if (mag > 32768) mag = 32768;
                pending.push_back(16'(-mag));
            end else begin
                if (mag > 32767) mag = 32767;
                pending.push_back(16'(mag));
            end
        endfunction

        function void check_result(input logic signed [15:0] got);
            logic signed [15:0] want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                $display("%0t: noise_value mismatch, expected %0d, actual %0d",
                         $time, want, got);
                errors++;
            end
        endfunction
    endclass

    noise_scoreboard sb;
    int sender_idle;
    longint cycles;

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        start = 0; i_x_coord = 0; i_y_coord = 0;
        i_cfg_we = 0; i_cfg_index = REG_SEED; i_cfg_data = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) sb.check_result(o_noise_value);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // start stays high across back-to-back transfers; idle cycles drop it
    task automatic send_point(input logic signed [31:0] xc, input logic signed [31:0] yc);
        while (sender_idle > 0 && $urandom_range(99) < sender_idle) begin
            start <= 0;
            @(posedge i_clk);
        end
        start <= 1;
        i_x_coord <= xc;
        i_y_coord <= yc;
        do @(posedge i_clk); while (busy);
        sb.note_input(xc, yc);
    endtask

    task automatic drain();
        start <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [63:0] v);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        if (idx == REG_SEED) sb.seed = v;
        else sb.rotated = v[0];
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(2097151)) - 1048576);
            2: return 32'($signed($urandom_range(4095)) - 2048);
            default: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
        endcase
    endfunction

    initial begin
        logic [63:0] seeds[4];
        sb = new();
        cycles = 0;
        sender_idle = 0;
        i_rst_n = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        seeds = '{64'h0, 64'h7FFFFFFFFFFFFFFF, 64'h8000000000000000, {$urandom, $urandom}};
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_SEED, seeds[ph]);
            write_reg(REG_ORIENT, {$urandom, 31'($urandom), ph[0]});
            // field extremes, lattice edges and saturation candidates
            send_point(32'sh7FFFFFFF, 32'sh7FFFFFFF);
            send_point(32'sh80000000, 32'sh80000000);
            send_point(32'sh7FFFFFFF, 32'sh80000000);
            send_point(32'sh80000000, 32'sh7FFFFFFF);
            send_point(0, 0);
            send_point(32'sh00010000, 0);
            send_point(0, 32'sh00010000);
            send_point(-1, -1);
            send_point(32'sh00008000, 32'sh00004000);
            send_point(32'sh00004000, 32'sh00008000);
            send_point(32'shFFFF0000, 32'sh0000C000);
            for (int k = 0; k < 100; k++) begin
                case (k / 25)
                    0: sender_idle = 0;
                    1: sender_idle = 61;
                    2: sender_idle = 18;
                    default: sender_idle = 0;
                endcase
                send_point(rand_coord(), rand_coord());
                if (k == 50) drain();
            end
            sender_idle = 0;
            drain();
        end
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

/* gradient_noise_2d_core.f */
hdl/gn2_pkg.sv
hdl/gradient_noise_2d_core.sv
tb/gradient_noise_2d_core_tb.sv
